// ===== src/ghc_pkg.sv =====
// ----------------------------------------------------------------------------
// ghc_pkg
// Shared types, codes and the per-plane multiply schedule of the collision check.
// ----------------------------------------------------------------------------
package ghc_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_SAFE = 2'd0;
  localparam logic [1:0] STAT_BOX  = 2'd1;
  localparam logic [1:0] STAT_RISK = 2'd2;

  localparam logic [2:0] REG_MARGIN = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_XMIN   = 3'd2;
  localparam logic [2:0] REG_XMAX   = 3'd3;
  localparam logic [2:0] REG_YMIN   = 3'd4;
  localparam logic [2:0] REG_YMAX   = 3'd5;

  // schedule length per plane, accumulator widths
  localparam int STEP_W = 5;
  localparam int STEPS  = 25;
  localparam int DW     = 66;
  localparam int QW     = 98;
  localparam int FW     = 148;
  localparam int KK_W   = 40;

  typedef enum logic [3:0] {
    A_A, A_B, A_C, A_T1L, A_T1H, A_T2L, A_T2H, A_T3L, A_T3H,
    A_D0, A_D1, A_Q0, A_Q1, A_Q2, A_Q3, A_K
  } asel_t;

  typedef enum logic [3:0] {
    B_A, B_B, B_MX, B_MY, B_NEGC, B_SXX, B_SXY, B_SYY,
    B_D0, B_D1, B_K0, B_K1, B_K
  } bsel_t;

  typedef enum logic [3:0] {
    D_NONE, D_T1, D_T2, D_T3, D_DL, D_DA, D_QL, D_QA, D_FL, D_FA, D_KK
  } dest_t;

  typedef struct packed {
    asel_t       asel;
    bsel_t       bsel;
    logic [7:0]  shamt;
    logic        neg;
    dest_t       dest;
  } uop_t;

  typedef struct packed {
    logic              run;
    logic [STEP_W-1:0] step;
    logic              sq_k;
  } dp_ctrl_t;

  // d = a*mx + b*my - c*2^16, q = a^2 sxx + 2ab sxy + b^2 syy,
  // f = d^2 * 2^16 - k^2 * q, plane clear when d and f are both non-negative
  function automatic uop_t decode_step(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{A_A, B_A, 8'd0, 1'b0, D_NONE};
    case (step)
      5'd0:  u = '{A_A,   B_A,    8'd0,   1'b0, D_T1};
      5'd1:  u = '{A_A,   B_B,    8'd0,   1'b0, D_T2};
      5'd2:  u = '{A_B,   B_B,    8'd0,   1'b0, D_T3};
      5'd3:  u = '{A_A,   B_MX,   8'd0,   1'b0, D_DL};
      5'd4:  u = '{A_B,   B_MY,   8'd0,   1'b0, D_DA};
      5'd5:  u = '{A_C,   B_NEGC, 8'd0,   1'b0, D_DA};
      5'd6:  u = '{A_T1L, B_SXX,  8'd0,   1'b0, D_QL};
      5'd7:  u = '{A_T1H, B_SXX,  8'd32,  1'b0, D_QA};
      5'd8:  u = '{A_T2L, B_SXY,  8'd1,   1'b0, D_QA};
      5'd9:  u = '{A_T2H, B_SXY,  8'd33,  1'b0, D_QA};
      5'd10: u = '{A_T3L, B_SYY,  8'd0,   1'b0, D_QA};
      5'd11: u = '{A_T3H, B_SYY,  8'd32,  1'b0, D_QA};
      5'd12: u = '{A_D0,  B_D0,   8'd16,  1'b0, D_FL};
      5'd13: u = '{A_D0,  B_D1,   8'd49,  1'b0, D_FA};
      5'd14: u = '{A_D1,  B_D1,   8'd80,  1'b0, D_FA};
      5'd15: u = '{A_Q0,  B_K0,   8'd0,   1'b1, D_FA};
      5'd16: u = '{A_Q0,  B_K1,   8'd32,  1'b1, D_FA};
      5'd17: u = '{A_Q1,  B_K0,   8'd32,  1'b1, D_FA};
      5'd18: u = '{A_Q1,  B_K1,   8'd64,  1'b1, D_FA};
      5'd19: u = '{A_Q2,  B_K0,   8'd64,  1'b1, D_FA};
      5'd20: u = '{A_Q2,  B_K1,   8'd96,  1'b1, D_FA};
      5'd21: u = '{A_Q3,  B_K0,   8'd96,  1'b1, D_FA};
      5'd22: u = '{A_Q3,  B_K1,   8'd128, 1'b1, D_FA};
      default: u = '{A_A, B_A, 8'd0, 1'b0, D_NONE};
    endcase
    return u;
  endfunction

endpackage

// ===== src/ghc_ram.sv =====
// ----------------------------------------------------------------------------
// ghc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ghc_datapath.sv =====
// ----------------------------------------------------------------------------
// ghc_datapath
// Shared 33x33 multiplier and accumulators that test one half-plane per pass.
// ----------------------------------------------------------------------------
module ghc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ghc_pkg::dp_ctrl_t   ctrl,
  input  logic [95:0]         plane,
  input  logic [19:0]         margin_scale,
  input  logic [31:0]         mean_x,
  input  logic [31:0]         mean_y,
  input  logic [31:0]         cov_xx,
  input  logic [31:0]         cov_xy,
  input  logic [31:0]         cov_yy,
  output logic                plane_pass
);

  ghc_pkg::uop_t  u;
  ghc_pkg::dest_t dest_q;
  logic [7:0]     shamt_q;
  logic           neg_q;

  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] prod_next;
  logic signed [65:0] prod;

  logic [63:0]                t1;
  logic [63:0]                t2;
  logic [63:0]                t3;
  logic [ghc_pkg::DW-1:0]     dacc;
  logic [ghc_pkg::QW-1:0]     qacc;
  logic [ghc_pkg::FW-1:0]     facc;
  logic [ghc_pkg::KK_W-1:0]   kk;
  logic [ghc_pkg::FW-1:0]     shifted;
  logic [ghc_pkg::FW-1:0]     term;

  logic [31:0] ca;
  logic [31:0] cb;
  logic [31:0] cc;

  assign ca = plane[95:64];
  assign cb = plane[63:32];
  assign cc = plane[31:0];

  always_comb begin
    if (ctrl.sq_k) begin
      u = '{ghc_pkg::A_K, ghc_pkg::B_K, 8'd0, 1'b0, ghc_pkg::D_KK};
    end else if (ctrl.run) begin
      u = ghc_pkg::decode_step(ctrl.step);
    end else begin
      u = '{ghc_pkg::A_A, ghc_pkg::B_A, 8'd0, 1'b0, ghc_pkg::D_NONE};
    end
  end

  always_comb begin
    case (u.asel)
      ghc_pkg::A_A:   opa = {ca[31], ca};
      ghc_pkg::A_B:   opa = {cb[31], cb};
      ghc_pkg::A_C:   opa = {cc[31], cc};
      ghc_pkg::A_T1L: opa = {1'b0, t1[31:0]};
      ghc_pkg::A_T1H: opa = {t1[63], t1[63:32]};
      ghc_pkg::A_T2L: opa = {1'b0, t2[31:0]};
      ghc_pkg::A_T2H: opa = {t2[63], t2[63:32]};
      ghc_pkg::A_T3L: opa = {1'b0, t3[31:0]};
      ghc_pkg::A_T3H: opa = {t3[63], t3[63:32]};
      ghc_pkg::A_D0:  opa = {1'b0, dacc[31:0]};
      ghc_pkg::A_D1:  opa = {1'b0, dacc[63:32]};
      ghc_pkg::A_Q0:  opa = {1'b0, qacc[31:0]};
      ghc_pkg::A_Q1:  opa = {1'b0, qacc[63:32]};
      ghc_pkg::A_Q2:  opa = {1'b0, qacc[95:64]};
      ghc_pkg::A_Q3:  opa = {{31{qacc[97]}}, qacc[97:96]};
      ghc_pkg::A_K:   opa = {13'd0, margin_scale};
      default:        opa = '0;
    endcase
  end

  always_comb begin
    case (u.bsel)
      ghc_pkg::B_A:    opb = {ca[31], ca};
      ghc_pkg::B_B:    opb = {cb[31], cb};
      ghc_pkg::B_MX:   opb = {mean_x[31], mean_x};
      ghc_pkg::B_MY:   opb = {mean_y[31], mean_y};
      ghc_pkg::B_NEGC: opb = 33'h1_FFFF_0000;
      ghc_pkg::B_SXX:  opb = {1'b0, cov_xx};
      ghc_pkg::B_SXY:  opb = {cov_xy[31], cov_xy};
      ghc_pkg::B_SYY:  opb = {1'b0, cov_yy};
      ghc_pkg::B_D0:   opb = {1'b0, dacc[31:0]};
      ghc_pkg::B_D1:   opb = {1'b0, dacc[63:32]};
      ghc_pkg::B_K0:   opb = {1'b0, kk[31:0]};
      ghc_pkg::B_K1:   opb = {25'd0, kk[39:32]};
      ghc_pkg::B_K:    opb = {13'd0, margin_scale};
      default:         opb = '0;
    endcase
  end

  assign prod_next = opa * opb;

  // product sign-extended to the final accumulator, then placed by the schedule
  assign shifted = {{(ghc_pkg::FW-66){prod[65]}}, prod} << shamt_q;
  assign term    = neg_q ? (~shifted + 1'b1) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_q <= ghc_pkg::D_NONE;
    end else begin
      dest_q <= u.dest;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_next;
    shamt_q <= u.shamt;
    neg_q   <= u.neg;
    case (dest_q)
      ghc_pkg::D_T1: t1   <= prod[63:0];
      ghc_pkg::D_T2: t2   <= prod[63:0];
      ghc_pkg::D_T3: t3   <= prod[63:0];
      ghc_pkg::D_DL: dacc <= prod;
      ghc_pkg::D_DA: dacc <= dacc + prod;
      ghc_pkg::D_QL: qacc <= term[ghc_pkg::QW-1:0];
      ghc_pkg::D_QA: qacc <= qacc + term[ghc_pkg::QW-1:0];
      ghc_pkg::D_FL: facc <= term;
      ghc_pkg::D_FA: facc <= facc + term;
      ghc_pkg::D_KK: kk   <= prod[ghc_pkg::KK_W-1:0];
      default: begin
      end
    endcase
  end

  assign plane_pass = !dacc[ghc_pkg::DW-1] && !facc[ghc_pkg::FW-1];

endmodule

// ===== src/gaussian_halfplane_collision_check.sv =====
// ----------------------------------------------------------------------------
// gaussian_halfplane_collision_check
// Chance-constrained collision check of a Gaussian position against obstacles
// stored as half-plane lines.
// ----------------------------------------------------------------------------
// A load transaction writes one line into the plane memory and gives no
// result. A query ends in its start state when the mean lies outside the
// workspace box or no obstacle is in use; otherwise it runs the schedule once
// for every plane it examines, at most MAX_OBSTACLES * PLANES_PER_OBSTACLE
// planes. The schedule is set by the single shared 33x33 multiplier, which
// steps through 23 partial products of the exact margin test, then drains its
// pipeline before the decision.
// One transaction is worked on at a time; a new one is taken while a result
// still waits on the output register.
module gaussian_halfplane_collision_check #(
  parameter int MAX_OBSTACLES       = 64,
  parameter int PLANES_PER_OBSTACLE = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [5:0]  obstacle_index,
  input  logic [1:0]  plane_index,
  input  logic [31:0] coef_a,
  input  logic [31:0] coef_b,
  input  logic [31:0] coef_c,
  input  logic [31:0] mean_x,
  input  logic [31:0] mean_y,
  input  logic [31:0] cov_xx,
  input  logic [31:0] cov_xy,
  input  logic [31:0] cov_yy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  blocking_obstacle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SLOTS  = MAX_OBSTACLES * PLANES_PER_OBSTACLE;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int OBS_W  = $clog2(MAX_OBSTACLES + 1);
  localparam int PL_W   = $clog2(PLANES_PER_OBSTACLE);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_RUN   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [19:0]        margin_scale;
  logic [6:0]         obstacle_count;
  logic signed [31:0] x_min;
  logic signed [31:0] x_max;
  logic signed [31:0] y_min;
  logic signed [31:0] y_max;

  logic signed [31:0] q_mx;
  logic signed [31:0] q_my;
  logic [31:0]        q_sxx;
  logic [31:0]        q_sxy;
  logic [31:0]        q_syy;

  logic [ADDR_W-1:0]         raddr;
  logic [ADDR_W-1:0]         raddr_next;
  logic [ADDR_W-1:0]         base;
  logic [OBS_W-1:0]          obs_idx;
  logic [PL_W-1:0]           plane_idx;
  logic [ghc_pkg::STEP_W-1:0] step;
  logic [1:0]                res_status;
  logic [5:0]                res_block;

  logic              accept;
  logic              q_accept;
  logic              ld_ok;
  logic              ld_we;
  logic [15:0]       ld_full;
  logic [95:0]       rdata;
  logic              box_out;
  logic [OBS_W-1:0]  cnt;
  logic              last_step;
  logic              plane_pass;
  logic              fin;
  logic [1:0]        fin_status;
  logic [5:0]        fin_block;
  logic              out_free;
  ghc_pkg::dp_ctrl_t ctrl;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign q_accept  = accept && (op == ghc_pkg::OP_QUERY);

  assign ld_ok   = (32'(obstacle_index) < 32'(MAX_OBSTACLES)) &&
                   (32'(plane_index) < 32'(PLANES_PER_OBSTACLE));
  assign ld_we   = accept && (op == ghc_pkg::OP_LOAD) && ld_ok;
  assign ld_full = 16'(obstacle_index) * 16'(PLANES_PER_OBSTACLE) + 16'(plane_index);

  ghc_ram #(
    .WIDTH (96),
    .DEPTH (SLOTS)
  ) u_planes (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_full[ADDR_W-1:0]),
    .wdata ({coef_a, coef_b, coef_c}),
    .raddr (raddr_next),
    .rdata (rdata)
  );

  assign ctrl.run  = (state == S_RUN);
  assign ctrl.step = step;
  assign ctrl.sq_k = (state == S_START);

  ghc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .plane        (rdata),
    .margin_scale (margin_scale),
    .mean_x       (q_mx),
    .mean_y       (q_my),
    .cov_xx       (q_sxx),
    .cov_xy       (q_sxy),
    .cov_yy       (q_syy),
    .plane_pass   (plane_pass)
  );

  assign box_out = (q_mx < x_min) || (q_mx > x_max) || (q_my < y_min) || (q_my > y_max);
  assign cnt     = (32'(obstacle_count) > 32'(MAX_OBSTACLES)) ? OBS_W'(MAX_OBSTACLES)
                                                              : OBS_W'(obstacle_count);
  assign last_step = (state == S_RUN) && (step == ghc_pkg::STEP_W'(ghc_pkg::STEPS - 1));
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    fin        = 1'b0;
    fin_status = ghc_pkg::STAT_SAFE;
    fin_block  = 6'd0;
    if (state == S_START) begin
      if (box_out) begin
        fin        = 1'b1;
        fin_status = ghc_pkg::STAT_BOX;
      end else if (cnt == '0) begin
        fin = 1'b1;
      end
    end else if (state == S_DONE) begin
      fin        = 1'b1;
      fin_status = res_status;
      fin_block  = res_block;
    end else if (last_step) begin
      if (plane_pass) begin
        fin = ((obs_idx + OBS_W'(1)) == cnt);
      end else if (plane_idx == PL_W'(PLANES_PER_OBSTACLE - 1)) begin
        // every plane of this obstacle failed
        fin        = 1'b1;
        fin_status = ghc_pkg::STAT_RISK;
        fin_block  = 6'(obs_idx);
      end
    end
  end

  // read address of the next plane, so its line is ready at the first step
  always_comb begin
    raddr_next = raddr;
    if ((state == S_IDLE) && q_accept) begin
      raddr_next = '0;
    end else if (last_step && !fin) begin
      if (plane_pass) begin
        raddr_next = base + ADDR_W'(PLANES_PER_OBSTACLE);
      end else begin
        raddr_next = raddr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      margin_scale   <= 20'd0;
      obstacle_count <= 7'd0;
      x_min          <= 32'sh8000_0000;
      x_max          <= 32'sh7FFF_FFFF;
      y_min          <= 32'sh8000_0000;
      y_max          <= 32'sh7FFF_FFFF;
      raddr          <= '0;
      base           <= '0;
      obs_idx        <= '0;
      plane_idx      <= '0;
      step           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ghc_pkg::REG_MARGIN: margin_scale   <= cfg_data[19:0];
          ghc_pkg::REG_COUNT:  obstacle_count <= cfg_data[6:0];
          ghc_pkg::REG_XMIN:   x_min          <= cfg_data;
          ghc_pkg::REG_XMAX:   x_max          <= cfg_data;
          ghc_pkg::REG_YMIN:   y_min          <= cfg_data;
          ghc_pkg::REG_YMAX:   y_max          <= cfg_data;
          default: begin
          end
        endcase
      end

      raddr <= raddr_next;

      case (state)
        S_IDLE: begin
          if (q_accept) begin
            base      <= '0;
            obs_idx   <= '0;
            plane_idx <= '0;
            state     <= S_START;
          end
        end
        S_START: begin
          if (!fin) begin
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_step) begin
            step <= '0;
            if (!fin) begin
              if (plane_pass) begin
                obs_idx   <= obs_idx + OBS_W'(1);
                plane_idx <= '0;
                base      <= base + ADDR_W'(PLANES_PER_OBSTACLE);
              end else begin
                plane_idx <= plane_idx + PL_W'(1);
              end
            end
          end else begin
            step <= step + ghc_pkg::STEP_W'(1);
          end
        end
        S_DONE: begin
        end
        default: state <= S_IDLE;
      endcase

      // result goes to the output register, or waits while it is occupied
      if (fin) begin
        if (out_free) begin
          state <= S_IDLE;
        end else begin
          state <= S_DONE;
        end
      end

      if (fin && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_accept) begin
      q_mx  <= mean_x;
      q_my  <= mean_y;
      q_sxx <= cov_xx;
      q_sxy <= cov_xy;
      q_syy <= cov_yy;
    end
    if (fin && out_free) begin
      status            <= fin_status;
      blocking_obstacle <= fin_block;
    end
    if (fin && !out_free && (state != S_DONE)) begin
      res_status <= fin_status;
      res_block  <= fin_block;
    end
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    q_accept |=> state == S_START)
    else $error("query transaction did not start the check");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step < ghc_pkg::STEP_W'(ghc_pkg::STEPS))
    else $error("schedule step out of range");

  a_block_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ghc_pkg::STAT_RISK |-> blocking_obstacle == 6'd0)
    else $error("blocking obstacle set on a result without collision risk");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    ld_we |-> state == S_IDLE)
    else $error("plane memory written during a query");

endmodule

// ===== sim/gaussian_halfplane_collision_check_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_halfplane_collision_check_test
// Loads half-plane tables and runs queries under several workspace boxes,
// margins and obstacle counts. Every accepted query is scored against an
// exact wide-integer prediction of the margin test. Both handshakes idle and
// stall at random.
// ----------------------------------------------------------------------------
module gaussian_halfplane_collision_check_test;

  localparam int NOBS    = 64;
  localparam int NPL     = 4;
  localparam int WD_MAX  = 40000;

  typedef struct {
    logic        op;
    logic [5:0]  obs;
    logic [1:0]  pl;
    logic [31:0] a, b, c, mx, my, sxx, sxy, syy;
  } txn_t;

  typedef struct {
    logic [1:0] status;
    logic [5:0] blk;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [5:0]  obstacle_index = '0;
  logic [1:0]  plane_index = '0;
  logic [31:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic [31:0] mean_x = '0, mean_y = '0, cov_xx = '0, cov_xy = '0, cov_yy = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [5:0]  blocking_obstacle;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gaussian_halfplane_collision_check u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the block's registers and plane memory
  logic [19:0]        k_scale;
  logic [6:0]         n_obs;
  logic signed [31:0] bx_lo, bx_hi, by_lo, by_hi;
  logic [31:0]        tbl_a [NOBS*NPL];
  logic [31:0]        tbl_b [NOBS*NPL];
  logic [31:0]        tbl_c [NOBS*NPL];

  txn_t     pend_q[$];
  verdict_t verdict_q[$];
  int       errors = 0;
  int       n_acc = 0;
  bit       in_fired = 0;
  bit       quiet;
  int       hold_cnt = 0;
  bit       hold_done = 0;
  int       idle_cycles = 0;

  assign quiet = (n_acc >= 300 && n_acc < 500);

  task automatic add_txn(txn_t t);
    pend_q.insert(pend_q.size(), t);
  endtask

  function automatic bit line_clears(int slot, logic [31:0] mx, logic [31:0] my,
                                     logic [31:0] sxx, logic [31:0] sxy,
                                     logic [31:0] syy);
    logic signed [159:0] a, b, c, x, y, vxx, vxy, vyy, d, q, lhs, rhs, kk;
    a = 160'($signed(tbl_a[slot]));
    b = 160'($signed(tbl_b[slot]));
    c = 160'($signed(tbl_c[slot]));
    x = 160'($signed(mx));
    y = 160'($signed(my));
    vxx = $signed({128'd0, sxx});
    vxy = 160'($signed(sxy));
    vyy = $signed({128'd0, syy});
    kk = $signed({140'd0, k_scale});
    d = a * x + b * y - (c <<< 16);
    if (d < 0) return 1'b0;
    q = a * a * vxx + 2 * a * b * vxy + b * b * vyy;
    // indefinite covariance gives no margin
    if (q < 0) q = 0;
    lhs = (d * d) <<< 16;
    rhs = q * kk * kk;
    return lhs >= rhs;
  endfunction

  function automatic verdict_t judge_query(txn_t t);
    verdict_t v;
    int lim;
    bit ok;
    v.status = ghc_pkg::STAT_SAFE;
    v.blk = '0;
    if ($signed(t.mx) < bx_lo || $signed(t.mx) > bx_hi ||
        $signed(t.my) < by_lo || $signed(t.my) > by_hi) begin
      v.status = ghc_pkg::STAT_BOX;
      return v;
    end
    lim = (n_obs > NOBS) ? NOBS : n_obs;
    for (int o = 0; o < lim; o++) begin
      ok = 0;
      for (int p = 0; p < NPL && !ok; p++)
        ok = line_clears(o * NPL + p, t.mx, t.my, t.sxx, t.sxy, t.syy);
      if (!ok) begin
        v.status = ghc_pkg::STAT_RISK;
        v.blk = o[5:0];
        return v;
      end
    end
    return v;
  endfunction

  // input side: predict on every accepted transaction
  always @(posedge clk) begin
    txn_t t;
    if (!rst && in_valid && !in_stall) begin
      t.op = op; t.obs = obstacle_index; t.pl = plane_index;
      t.a = coef_a; t.b = coef_b; t.c = coef_c;
      t.mx = mean_x; t.my = mean_y; t.sxx = cov_xx; t.sxy = cov_xy; t.syy = cov_yy;
      if (t.op == ghc_pkg::OP_LOAD) begin
        tbl_a[t.obs * NPL + t.pl] = t.a;
        tbl_b[t.obs * NPL + t.pl] = t.b;
        tbl_c[t.obs * NPL + t.pl] = t.c;
      end else begin
        verdict_q.insert(verdict_q.size(), judge_query(t));
      end
      in_fired = 1;
      n_acc++;
    end
  end

  always @(negedge clk) begin
    txn_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (pend_q.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
        t = pend_q.pop_front();
        op <= t.op; obstacle_index <= t.obs; plane_index <= t.pl;
        coef_a <= t.a; coef_b <= t.b; coef_c <= t.c;
        mean_x <= t.mx; mean_y <= t.my;
        cov_xx <= t.sxx; cov_xy <= t.sxy; cov_yy <= t.syy;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_fired = 0;
  end

  // output side: long hold once, so the block backs up onto its input
  always @(negedge clk) begin
    if (!hold_done && n_acc >= 700) begin
      hold_done = 1;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d blocking=%0d",
                 $time, status, blocking_obstacle);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        if (status !== v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, v.status, status);
          errors++;
        end
        if (blocking_obstacle !== v.blk) begin
          $display("%0t: blocking_obstacle expected %0d actual %0d",
                   $time, v.blk, blocking_obstacle);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ghc_pkg::REG_MARGIN: k_scale = val[19:0];
      ghc_pkg::REG_COUNT:  n_obs = val[6:0];
      ghc_pkg::REG_XMIN:   bx_lo = val;
      ghc_pkg::REG_XMAX:   bx_hi = val;
      ghc_pkg::REG_YMIN:   by_lo = val;
      ghc_pkg::REG_YMAX:   by_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [19:0] k, logic [6:0] n, int xl, int xh, int yl, int yh);
    write_reg(ghc_pkg::REG_MARGIN, {12'd0, k});
    write_reg(ghc_pkg::REG_COUNT, {25'd0, n});
    write_reg(ghc_pkg::REG_XMIN, xl);
    write_reg(ghc_pkg::REG_XMAX, xh);
    write_reg(ghc_pkg::REG_YMIN, yl);
    write_reg(ghc_pkg::REG_YMAX, yh);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pend_q.size() > 0 || in_valid || verdict_q.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic int span(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic txn_t noise();
    txn_t t;
    t.op = 1'($urandom_range(1)); t.obs = 6'($urandom); t.pl = 2'($urandom);
    t.a = $urandom; t.b = $urandom; t.c = $urandom;
    t.mx = $urandom; t.my = $urandom;
    t.sxx = $urandom; t.sxy = $urandom; t.syy = $urandom;
    return t;
  endfunction

  function automatic txn_t mk_load(int o, int p, int a, int b, int c);
    txn_t t;
    t = noise();
    t.op = ghc_pkg::OP_LOAD; t.obs = 6'(o); t.pl = 2'(p); t.a = a; t.b = b; t.c = c;
    return t;
  endfunction

  function automatic txn_t mk_query(int mx, int my, logic [31:0] sxx, int sxy,
                                    logic [31:0] syy);
    txn_t t;
    t = noise();
    t.op = ghc_pkg::OP_QUERY; t.mx = mx; t.my = my; t.sxx = sxx; t.sxy = sxy;
    t.syy = syy;
    return t;
  endfunction

  function automatic txn_t plain_load();
    return mk_load($urandom_range(63), $urandom_range(3), span(4 << 16), span(4 << 16),
                   span(16 << 16));
  endfunction

  function automatic txn_t plain_query();
    return mk_query(span(8 << 16), span(8 << 16), $urandom_range(1 << 16),
                    span(1 << 15), $urandom_range(1 << 16));
  endfunction

  task automatic random_mix(int n, int load_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 10) add_txn(noise());
      else if (r < 10 + load_pct) add_txn(plain_load());
      else add_txn(plain_query());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    k_scale = '0; n_obs = '0;
    bx_lo = 32'h8000_0000; bx_hi = 32'h7fff_ffff;
    by_lo = 32'h8000_0000; by_hi = 32'h7fff_ffff;

    // reset state: no obstacles, widest box, extreme means; then a full table load
    add_txn(mk_query(32'h8000_0000, 32'h8000_0000, '1, 32'h8000_0000, '1));
    add_txn(mk_query(32'h7fff_ffff, 32'h7fff_ffff, '0, 32'h7fff_ffff, '0));
    add_txn(mk_load(63, 3, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    add_txn(mk_load(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    for (int s = 0; s < NOBS * NPL; s++)
      add_txn(mk_load(s / NPL, s % NPL, span(4 << 16), span(4 << 16),
                      span(16 << 16)));
    drain();

    set_regs(20'h10000, 7'd4, -(16 << 16), 16 << 16, -(16 << 16), 16 << 16);
    // mean on each bound and just past it
    add_txn(mk_query(-(16 << 16), 0, 1 << 16, 0, 1 << 16));
    add_txn(mk_query(16 << 16, 0, 1 << 16, 0, 1 << 16));
    add_txn(mk_query(0, -(16 << 16), 1 << 16, 0, 1 << 16));
    add_txn(mk_query(0, 16 << 16, 1 << 16, 0, 1 << 16));
    add_txn(mk_query(-(16 << 16) - 1, 0, 0, 0, 0));
    add_txn(mk_query((16 << 16) + 1, 0, 0, 0, 0));
    add_txn(mk_query(0, -(16 << 16) - 1, 0, 0, 0));
    add_txn(mk_query(0, (16 << 16) + 1, 0, 0, 0));
    // indefinite covariance
    add_txn(mk_query(0, 0, 1, 32'h7fff_ffff, 1));
    add_txn(mk_query(0, 0, 1, 32'h8000_0000, 1));
    add_txn(mk_query(1 << 16, -(1 << 16), '1, 0, '1));
    random_mix(300, 30);
    drain();

    // empty box in x, then in y
    set_regs(20'h08000, 7'd3, 1 << 16, -(1 << 16), -(16 << 16), 16 << 16);
    random_mix(30, 20);
    drain();
    write_reg(ghc_pkg::REG_XMIN, -(16 << 16));
    write_reg(ghc_pkg::REG_XMAX, 16 << 16);
    write_reg(ghc_pkg::REG_YMIN, 2 << 16);
    write_reg(ghc_pkg::REG_YMAX, 1 << 16);
    random_mix(30, 20);
    drain();

    // every obstacle in use, no margin
    set_regs(20'd0, 7'd64, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    repeat (12) add_txn(plain_query());
    drain();

    // count beyond the table, largest margin
    set_regs(20'hfffff, 7'd127, -(16 << 16), 16 << 16, -(16 << 16), 16 << 16);
    random_mix(40, 20);
    drain();

    repeat (6) begin
      set_regs(20'($urandom_range(3 << 16)), 7'($urandom_range(1, 8)),
               -int'($urandom_range(4 << 16, 12 << 16)), $urandom_range(4 << 16, 12 << 16),
               -int'($urandom_range(4 << 16, 12 << 16)), $urandom_range(4 << 16, 12 << 16));
      random_mix(150, 30);
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
